// ===== sv/ppc_pkg.sv =====
// ----------------------------------------------------------------------------
// ppc_pkg
// Types and codes shared by the paired postings cursor modules.
// ----------------------------------------------------------------------------
package ppc_pkg;

    localparam int CMD_W    = 2;
    localparam int COUNT_W  = 11;
    localparam int INDEX_W  = 10;
    localparam int KEY_W    = 32;
    localparam int TARGET_W = 64;
    localparam int PAIR_W   = 2 * KEY_W;

    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NEXT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEEK = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [INDEX_W-1:0]  load_index;
        logic [KEY_W-1:0]    load_offset;
        logic [KEY_W-1:0]    load_series;
        logic [TARGET_W-1:0] target;
    } ppc_in_t;

    typedef struct packed {
        logic             found;
        logic [KEY_W-1:0] cur_offset_out;
        logic [KEY_W-1:0] cur_series_out;
    } ppc_out_t;

    // store read address source
    typedef enum logic [1:0] {
        RD_ZERO,
        RD_NEXT,
        RD_LO,
        RD_PROBE
    } ppc_rd_sel_t;

    typedef struct packed {
        logic        capture;
        logic        load_apply;
        logic        set_found;
        ppc_rd_sel_t rd_sel;
        logic        take;
        logic        search_init;
        logic        probe_update;
        logic        exhaust;
        logic        out_load;
    } ppc_ctrl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             eff_zero;
        logic             started;
        logic             next_at_end;
        logic             past_end;
        logic             cur_ge_target;
        logic             count_zero;
        logic             lo_ge_n;
    } ppc_stat_t;

endpackage

// ===== sv/ppc_ram.sv =====
// ----------------------------------------------------------------------------
// ppc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ppc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/ppc_datapath.sv =====
// ----------------------------------------------------------------------------
// ppc_datapath
// Cursor state, search registers, pair store and result register.
// ----------------------------------------------------------------------------
module ppc_datapath #(
    parameter int DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [ppc_pkg::COUNT_W-1:0]   cfg_wr_data,
    input  ppc_pkg::ppc_in_t              in_data,
    input  ppc_pkg::ppc_ctrl_t            ctrl,
    output ppc_pkg::ppc_stat_t            stat,
    output ppc_pkg::ppc_out_t             out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW = $clog2(DEPTH + 1);
    localparam logic [31:0] DEPTH_W = 32'(DEPTH);

    ppc_pkg::ppc_in_t               item_reg;
    ppc_pkg::ppc_out_t              out_reg;
    logic [ppc_pkg::COUNT_W-1:0]    entry_count_reg;
    logic [PW-1:0]                  cursor_pos_reg;
    logic                           started_reg;
    logic [ppc_pkg::KEY_W-1:0]      cur_offset_reg;
    logic [ppc_pkg::KEY_W-1:0]      cur_series_reg;
    logic                           found_reg;
    logic [PW-1:0]                  lo_reg;
    logic [PW-1:0]                  count_reg;
    logic [PW-1:0]                  rd_pos_reg;

    logic [PW-1:0]                  eff_count;
    logic [PW:0]                    next_pos;
    logic [PW-1:0]                  step;
    logic [PW-1:0]                  probe;
    logic [PW-1:0]                  rd_pos;
    logic                           idx_in_range;
    logic                           ram_we;
    logic [ppc_pkg::PAIR_W-1:0]     rdata;
    logic                           probe_below;

    // effective count is min(entry_count, DEPTH)
    always_comb
    begin
        if ({21'b0, entry_count_reg} >= DEPTH_W)
        begin
            eff_count = PW'(DEPTH);
        end
        else
        begin
            eff_count = PW'(entry_count_reg);
        end
    end

    assign next_pos     = {1'b0, cursor_pos_reg} + {{PW{1'b0}}, 1'b1};
    assign step         = count_reg >> 1;
    assign probe        = lo_reg + step;
    assign idx_in_range = ({22'b0, item_reg.load_index} < DEPTH_W);
    assign ram_we       = ctrl.load_apply && idx_in_range;
    assign probe_below  = ({32'b0, rdata[ppc_pkg::PAIR_W-1:ppc_pkg::KEY_W]} < item_reg.target);

    always_comb
    begin
        unique case (ctrl.rd_sel)
            ppc_pkg::RD_ZERO:  rd_pos = '0;
            ppc_pkg::RD_NEXT:  rd_pos = PW'(next_pos);
            ppc_pkg::RD_LO:    rd_pos = lo_reg;
            ppc_pkg::RD_PROBE: rd_pos = probe;
            default:           rd_pos = '0;
        endcase
    end

    ppc_ram #(
        .WIDTH (ppc_pkg::PAIR_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(item_reg.load_index)),
        .wdata ({item_reg.load_offset, item_reg.load_series}),
        .raddr (AW'(rd_pos)),
        .rdata (rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            cursor_pos_reg  <= '0;
            started_reg     <= 1'b0;
            cur_offset_reg  <= '0;
            cur_series_reg  <= '0;
            found_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                entry_count_reg <= cfg_wr_data;
            end
            if (ctrl.capture)
            begin
                found_reg <= 1'b0;
            end
            if (ctrl.set_found)
            begin
                found_reg <= 1'b1;
            end
            if (ctrl.load_apply)
            begin
                cursor_pos_reg <= '0;
                started_reg    <= 1'b0;
                cur_offset_reg <= '0;
                cur_series_reg <= '0;
            end
            if (ctrl.take)
            begin
                cursor_pos_reg <= rd_pos_reg;
                started_reg    <= 1'b1;
                cur_offset_reg <= rdata[ppc_pkg::PAIR_W-1:ppc_pkg::KEY_W];
                cur_series_reg <= rdata[ppc_pkg::KEY_W-1:0];
            end
            if (ctrl.exhaust)
            begin
                cursor_pos_reg <= eff_count;
            end
        end
    end

    // payload and search registers
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            item_reg <= in_data;
        end
        rd_pos_reg <= rd_pos;
        if (ctrl.search_init)
        begin
            lo_reg <= PW'(next_pos);
            if (next_pos < {1'b0, eff_count})
            begin
                count_reg <= eff_count - PW'(next_pos);
            end
            else
            begin
                count_reg <= '0;
            end
        end
        if (ctrl.probe_update)
        begin
            if (probe_below)
            begin
                lo_reg    <= rd_pos_reg + {{(PW-1){1'b0}}, 1'b1};
                count_reg <= count_reg - step - {{(PW-1){1'b0}}, 1'b1};
            end
            else
            begin
                count_reg <= step;
            end
        end
        if (ctrl.out_load)
        begin
            out_reg.found          <= found_reg;
            out_reg.cur_offset_out <= cur_offset_reg;
            out_reg.cur_series_out <= cur_series_reg;
        end
    end

    assign out_data = out_reg;

    always_comb
    begin
        stat.cmd           = item_reg.cmd;
        stat.eff_zero      = (eff_count == '0);
        stat.started       = started_reg;
        stat.next_at_end   = (next_pos >= {1'b0, eff_count});
        stat.past_end      = (cursor_pos_reg >= eff_count);
        stat.cur_ge_target = ({32'b0, cur_offset_reg} >= item_reg.target);
        stat.count_zero    = (count_reg == '0);
        stat.lo_ge_n       = (lo_reg >= eff_count);
    end

    a_rewound_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        !started_reg |-> cursor_pos_reg == '0)
        else $error("cursor moved while not started");

    a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.take |=> started_reg)
        else $error("taking an entry did not start the list");

    a_exhaust_pos: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.exhaust |=> cursor_pos_reg == $past(eff_count))
        else $error("exhausted seek left cursor off the count");

endmodule

// ===== sv/ppc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ppc_ctrl
// Sequencer for load, next and seek; drives the binary search over the store.
// ----------------------------------------------------------------------------
module ppc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  ppc_pkg::ppc_stat_t stat,
    output ppc_pkg::ppc_ctrl_t ctrl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_TK_FIRST,
        S_CMP,
        S_SEARCH,
        S_PROBE,
        S_TK_END,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ctrl           = '0;
        ctrl.rd_sel    = ppc_pkg::RD_ZERO;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_FINISH;
                if (stat.cmd == ppc_pkg::CMD_LOAD)
                begin
                    ctrl.load_apply = 1'b1;
                end
                else if (stat.cmd == ppc_pkg::CMD_NEXT)
                begin
                    if (!stat.eff_zero && !stat.started)
                    begin
                        ctrl.rd_sel = ppc_pkg::RD_ZERO;
                        state_next  = S_TK_END;
                    end
                    else if (!stat.eff_zero && !stat.next_at_end)
                    begin
                        ctrl.rd_sel = ppc_pkg::RD_NEXT;
                        state_next  = S_TK_END;
                    end
                end
                else if (stat.cmd == ppc_pkg::CMD_SEEK)
                begin
                    if (!stat.eff_zero && !stat.started)
                    begin
                        ctrl.rd_sel = ppc_pkg::RD_ZERO;
                        state_next  = S_TK_FIRST;
                    end
                    else if (!stat.eff_zero && !stat.past_end)
                    begin
                        state_next = S_CMP;
                    end
                end
            end
            S_TK_FIRST:
            begin
                ctrl.take  = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (stat.cur_ge_target)
                begin
                    ctrl.set_found = 1'b1;
                    state_next     = S_FINISH;
                end
                else
                begin
                    ctrl.search_init = 1'b1;
                    state_next       = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                priority if (!stat.count_zero)
                begin
                    ctrl.rd_sel = ppc_pkg::RD_PROBE;
                    state_next  = S_PROBE;
                end
                else if (stat.lo_ge_n)
                begin
                    ctrl.exhaust = 1'b1;
                    state_next   = S_FINISH;
                end
                else
                begin
                    ctrl.rd_sel = ppc_pkg::RD_LO;
                    state_next  = S_TK_END;
                end
            end
            S_PROBE:
            begin
                ctrl.probe_update = 1'b1;
                state_next        = S_SEARCH;
            end
            S_TK_END:
            begin
                ctrl.take      = 1'b1;
                ctrl.set_found = 1'b1;
                state_next     = S_FINISH;
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    ctrl.out_load  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_DISPATCH)
        else $error("accepted word not dispatched");

    a_finish_waits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FINISH && out_valid_reg && !out_ready |=> state_reg == S_FINISH)
        else $error("result dropped while output slot busy");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_load |-> state_reg == S_FINISH && slot_free)
        else $error("result loaded outside finish");

    a_one_take: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({ctrl.take, ctrl.exhaust, ctrl.load_apply}) <= 1)
        else $error("conflicting cursor updates");

endmodule

// ===== sv/paired_postings_cursor.sv =====
// ----------------------------------------------------------------------------
// paired_postings_cursor
// Cursor over a sorted store of (offset, series id) pairs with next and
// lower-bound seek.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_ready     in_data   (ppc_in_t)
//   out      output     out_valid / out_ready   out_data  (ppc_out_t)
//   cfg      input      cfg_wr_en               cfg_wr_data (entry_count)
//
// after accept, load goes from dispatch to the finish state; next passes through
// the take state when it takes an entry; seek takes the first entry if needed,
// compares it, then spends one registered store read and one compare per search
// halving. one word is worked on at a time; the next word can be accepted from
// the cycle after the result is parked in the output register.
// a result waiting on out_ready holds the sequencer in its final state.
// reset clears the cursor and entry_count; the store holds no reset value.
// ----------------------------------------------------------------------------
module paired_postings_cursor #(
    parameter int DEPTH = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [ppc_pkg::COUNT_W-1:0] cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  ppc_pkg::ppc_in_t            in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output ppc_pkg::ppc_out_t           out_data
);

    ppc_pkg::ppc_ctrl_t ctrl;
    ppc_pkg::ppc_stat_t stat;

    ppc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    ppc_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (in_data),
        .ctrl        (ctrl),
        .stat        (stat),
        .out_data    (out_data)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for paired_postings_cursor. Sorted lists of
// (offset, series) pairs are loaded. Next, lower-bound seek and reserved
// commands then run against a cursor model kept in the testbench. Every
// result word is compared in order while both handshakes idle and stall at
// random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DEPTH        = 1024;
    localparam int LONG_LEN     = 256;
    localparam int LIMIT_CYCLES = 500000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_WORDS = 260;

    localparam logic [ppc_pkg::CMD_W-1:0] CMD_RSVD = 2'd3;

    logic                        clk         = 1'b0;
    logic                        rst_n       = 1'b0;
    logic                        cfg_wr_en   = 1'b0;
    logic [ppc_pkg::COUNT_W-1:0] cfg_wr_data = '0;
    logic                        in_valid    = 1'b0;
    logic                        in_ready;
    ppc_pkg::ppc_in_t            in_data     = '0;
    logic                        out_valid;
    logic                        out_ready   = 1'b0;
    ppc_pkg::ppc_out_t           out_data;

    // cursor model state
    logic [ppc_pkg::PAIR_W-1:0] posting_mem [DEPTH];
    int unsigned                list_len    = 0;
    int unsigned                cursor_at   = 0;
    bit                         cursor_live = 1'b0;
    logic [ppc_pkg::KEY_W-1:0]  cur_key     = '0;
    logic [ppc_pkg::KEY_W-1:0]  cur_sid     = '0;

    ppc_pkg::ppc_out_t          answer_q [$];
    logic [ppc_pkg::KEY_W-1:0]  phase_keys [$];
    int unsigned                error_cnt  = 0;
    int unsigned                cycle_cnt  = 0;
    int unsigned                words_sent = 0;

    // sender pacing
    int unsigned       burst_left = 0;
    bit                gapless    = 1'b0;

    // receiver pacing
    int unsigned       hold_asks     = 0;
    int unsigned       hold_seen     = 0;
    int unsigned       hold_left     = 0;
    int unsigned       rx_mode       = 0;
    int unsigned       rx_mode_left  = 0;
    int unsigned       rx_stall_left = 0;
    int unsigned       rx_tick       = 0;

    paired_postings_cursor #(
        .DEPTH(DEPTH)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    always #2 clk = ~clk;

    function automatic int unsigned live_len();
        return (list_len < DEPTH) ? list_len : DEPTH;
    endfunction

    function automatic void move_to(input int unsigned pos);
        cursor_at = pos;
        cur_key   = posting_mem[pos][ppc_pkg::PAIR_W-1:ppc_pkg::KEY_W];
        cur_sid   = posting_mem[pos][ppc_pkg::KEY_W-1:0];
    endfunction

    function automatic bit step_forward();
        int unsigned n;
        n = live_len();
        if (n == 0)
            return 1'b0;
        if (!cursor_live)
        begin
            cursor_live = 1'b1;
            move_to(0);
            return 1'b1;
        end
        if (cursor_at + 1 >= n)
            return 1'b0;
        move_to(cursor_at + 1);
        return 1'b1;
    endfunction

    function automatic bit seek_lower_bound(input logic [ppc_pkg::TARGET_W-1:0] goal);
        int unsigned n;
        int unsigned lo;
        int unsigned span;
        int unsigned half;
        int unsigned probe;
        n = live_len();
        if (n == 0)
            return 1'b0;
        if (!cursor_live)
        begin
            if (!step_forward())
                return 1'b0;
        end
        else if (cursor_at >= n)
            return 1'b0;
        if ({32'd0, cur_key} >= goal)
            return 1'b1;
        lo   = cursor_at + 1;
        span = (lo < n) ? n - lo : 0;
        while (span > 0)
        begin
            half  = span / 2;
            probe = lo + half;
            if ({32'd0, posting_mem[probe][ppc_pkg::PAIR_W-1:ppc_pkg::KEY_W]} < goal)
            begin
                lo   = probe + 1;
                span = span - half - 1;
            end
            else
                span = half;
        end
        // nothing left reaches the target: park past the end
        if (lo >= n)
        begin
            cursor_at = n;
            return 1'b0;
        end
        move_to(lo);
        return 1'b1;
    endfunction

    function automatic ppc_pkg::ppc_out_t cursor_answer(input ppc_pkg::ppc_in_t w);
        ppc_pkg::ppc_out_t r;
        r.found = 1'b0;
        case (w.cmd)
            ppc_pkg::CMD_LOAD:
            begin
                if (w.load_index < DEPTH)
                    posting_mem[w.load_index] = {w.load_offset, w.load_series};
                cursor_live = 1'b0;
                cursor_at   = 0;
                cur_key     = '0;
                cur_sid     = '0;
            end
            ppc_pkg::CMD_NEXT: r.found = step_forward();
            ppc_pkg::CMD_SEEK: r.found = seek_lower_bound(w.target);
            default: ;
        endcase
        r.cur_offset_out = cur_key;
        r.cur_series_out = cur_sid;
        return r;
    endfunction

    // entered and left at a falling edge; valid stays up for a following word
    task automatic send_word(input ppc_pkg::ppc_in_t w);
        if (!gapless && burst_left == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        in_valid = 1'b1;
        in_data  = w;
        do
            @(posedge clk);
        while (!in_ready);
        answer_q.push_back(cursor_answer(w));
        words_sent++;
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
    endtask

    // unused fields carry random bits
    function automatic ppc_pkg::ppc_in_t cursor_word(input logic [ppc_pkg::CMD_W-1:0] cmd);
        ppc_pkg::ppc_in_t w;
        w.cmd         = cmd;
        w.load_index  = ppc_pkg::INDEX_W'($urandom);
        w.load_offset = $urandom;
        w.load_series = $urandom;
        w.target      = {$urandom, $urandom};
        return w;
    endfunction

    task automatic do_load(input int unsigned idx, input logic [ppc_pkg::KEY_W-1:0] key,
                           input logic [ppc_pkg::KEY_W-1:0] sid);
        ppc_pkg::ppc_in_t w;
        w             = cursor_word(ppc_pkg::CMD_LOAD);
        w.load_index  = ppc_pkg::INDEX_W'(idx);
        w.load_offset = key;
        w.load_series = sid;
        send_word(w);
    endtask

    task automatic do_next();
        send_word(cursor_word(ppc_pkg::CMD_NEXT));
    endtask

    task automatic do_seek(input logic [ppc_pkg::TARGET_W-1:0] goal);
        ppc_pkg::ppc_in_t w;
        w        = cursor_word(ppc_pkg::CMD_SEEK);
        w.target = goal;
        send_word(w);
    endtask

    task automatic do_rsvd();
        send_word(cursor_word(CMD_RSVD));
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (answer_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_entry_count(input int unsigned value);
        wait_idle();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = ppc_pkg::COUNT_W'(value);
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        list_len    = value;
    endtask

    // random mix of cursor commands, most seeks aimed at the keys of the current list
    task automatic run_ops(input int unsigned num);
        int unsigned                  sel;
        logic [ppc_pkg::TARGET_W-1:0] goal;
        repeat (num)
        begin
            sel = $urandom_range(0, 99);
            if (phase_keys.size() == 0)
                goal = {$urandom, $urandom};
            else
                goal = {32'd0, phase_keys[$urandom_range(0, phase_keys.size() - 1)]}
                       + $urandom_range(0, 1);
            if (sel < 40)
                do_seek(goal);
            else if (sel < 75)
                do_next();
            else if (sel < 85)
                do_seek({$urandom, $urandom} >> $urandom_range(0, 63));
            else if (sel < 93)
                do_load($urandom_range(0, DEPTH - 1), $urandom, $urandom);
            else if (sel < 97)
                do_rsvd();
            else
                do_seek((sel == 97) ? '0 : '1);
        end
    endtask

    task automatic test_empty_list();
        set_entry_count(0);
        do_next();
        do_seek('0);
        do_seek('1);
        do_rsvd();
        do_load(0, 32'h0000_0000, 32'hFFFF_FFFF);
        do_next();
    endtask

    task automatic test_short_list();
        do_load(1, 32'd10, 32'h1234_5678);
        do_load(2, 32'd10, 32'h9ABC_DEF0);
        do_load(3, 32'hFFFF_FFFF, 32'h0000_0000);
        do_load(DEPTH - 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        set_entry_count(4);
        // walk the list, the last one runs off the end
        repeat (5) do_next();
        do_load(0, 32'h0000_0000, 32'hFFFF_FFFF);
        do_seek(64'd0);
        do_seek(64'd10);
        do_seek(64'd5);
        do_seek(64'h1_0000_0000);
        do_next();
        do_seek(64'd0);
        do_rsvd();
        do_load(0, 32'h0000_0000, 32'hFFFF_FFFF);
        do_seek(64'hFFFF_FFFF);
        // shrink the list under the cursor
        set_entry_count(2);
        do_next();
        do_seek(64'd0);
    endtask

    task automatic test_long_list();
        int unsigned               i;
        logic [ppc_pkg::KEY_W-1:0] key;
        phase_keys.delete();
        for (i = 0; i < LONG_LEN; i++)
        begin
            if (i == 0)
                key = '0;
            else if (i == LONG_LEN - 1)
                key = '1;
            else
                key = ppc_pkg::KEY_W'(i * 32'h0100_0000 + $urandom_range(0, 32'h00FF_FFFF));
            phase_keys.push_back(key);
            do_load(i, key, $urandom);
        end
        set_entry_count(LONG_LEN);
        run_ops(40);
        set_entry_count(LONG_LEN - 56);
        run_ops(20);
    endtask

    task automatic test_backpressure();
        gapless = 1'b1;
        hold_asks++;
        run_ops(24);
        gapless = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_lists();
        int unsigned               first_word;
        int unsigned               len;
        int unsigned               lim;
        int unsigned               sel;
        int unsigned               i;
        bit                        backwards;
        logic [ppc_pkg::KEY_W-1:0] key;
        first_word = words_sent;
        while (words_sent - first_word < RANDOM_WORDS)
        begin
            sel = $urandom_range(0, 9);
            len = (sel < 7) ? $urandom_range(1, 32) : $urandom_range(33, 200);
            // dense lists are full of duplicate offsets
            lim = ($urandom_range(0, 3) == 0) ? 2 : 32'hFFFF_FFFF / (len + 1);
            key = $urandom_range(0, lim);
            phase_keys.delete();
            for (i = 0; i < len; i++)
            begin
                phase_keys.push_back(key);
                key = key + $urandom_range(0, lim);
            end
            gapless   = ($urandom_range(0, 3) == 0);
            backwards = ($urandom_range(0, 3) == 0);
            for (i = 0; i < len; i++)
            begin
                if (backwards)
                    do_load(len - 1 - i, phase_keys[len - 1 - i], $urandom);
                else
                    do_load(i, phase_keys[i], $urandom);
            end
            // entries past the list still hold pairs from earlier loads
            sel = $urandom_range(0, 9);
            if (sel == 0)
                set_entry_count($urandom_range(0, len));
            else if (sel == 1)
                set_entry_count($urandom_range(len, LONG_LEN));
            else
                set_entry_count(len);
            run_ops($urandom_range(5, 30));
        end
        gapless = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [ppc_pkg::KEY_W-1:0] want,
                               input logic [ppc_pkg::KEY_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            error_cnt++;
        end
    endtask

    always @(posedge clk)
    begin
        ppc_pkg::ppc_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (answer_q.size() == 0)
            begin
                $display("%0t: result word with nothing pending, expected none actual %h",
                         $time, out_data);
                error_cnt++;
            end
            else
            begin
                want = answer_q.pop_front();
                check_field("found", ppc_pkg::KEY_W'(want.found),
                            ppc_pkg::KEY_W'(out_data.found));
                check_field("cur_offset_out", want.cur_offset_out, out_data.cur_offset_out);
                check_field("cur_series_out", want.cur_series_out, out_data.cur_series_out);
            end
        end
    end

    // receiver: changing stall patterns plus one long hold-off on request
    always @(negedge clk)
    begin
        rx_tick++;
        if (hold_seen != hold_asks)
        begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (rx_mode_left == 0)
        begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(20, 120);
        end
        rx_mode_left--;
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready = 1'b0;
        end
        else
        begin
            case (rx_mode)
                0: out_ready = 1'b1;
                1: out_ready = $urandom_range(0, 1);
                2: out_ready = (rx_tick % 4 == 0);
                default:
                begin
                    if (rx_stall_left > 0)
                    begin
                        rx_stall_left--;
                        out_ready = 1'b0;
                    end
                    else
                    begin
                        out_ready = 1'b1;
                        if ($urandom_range(0, 5) == 0)
                            rx_stall_left = $urandom_range(3, 15);
                    end
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_empty_list();
        test_short_list();
        test_long_list();
        test_backpressure();
        test_random_lists();
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
sv/ppc_pkg.sv
sv/ppc_ram.sv
sv/ppc_datapath.sv
sv/ppc_ctrl.sv
sv/paired_postings_cursor.sv
tb/sv/tb_top.sv
